>>> rtl/core/assert_macros.svh
// Assertion macros shared by the sorted priority stack RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SPSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SPSU_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPSU_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/spsu_pkg.sv
// Shared codes for the sorted priority stack unit.
// Depends on nothing; imported by the top level.
package spsu_pkg;

	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

>>> rtl/core/sorted_priority_stack_unit.sv
// Sorted priority stack unit: sequencer, entry memory and result register.
// Depends on spsu_pkg, spsu_ram and assert_macros.svh.

// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with result_valid high; the receiver
// cannot stall it. Entries live in one memory in ascending priority order with
// the top of the stack at the highest used address, so a pop is one memory
// read, whose data the pop state registers as the result. A push walks the
// memory from the top downward through the single read port, moving each entry
// of strictly higher priority up one place, one entry per cycle, and writes the
// new entry into the place freed just above the first entry of no higher
// priority, or at the bottom. A pop on an empty stack, a push on a full stack
// and a push on an empty stack answer in the cycle after acceptance. A new
// request is taken during the cycle in which the previous result is shown.
// No clearing pass follows reset.
`include "assert_macros.svh"

module sorted_priority_stack_unit #(
	parameter int DEPTH         = 16,
	parameter int PRIORITY_BITS = 16,
	parameter int TAG_BITS      = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic [PRIORITY_BITS-1:0]     priority_req,
	input  logic [TAG_BITS-1:0]          tag,
	output logic                         result_valid,
	output logic [spsu_pkg::STATUS_W-1:0] status,
	output logic [PRIORITY_BITS-1:0]     out_priority,
	output logic [TAG_BITS-1:0]          out_tag,
	output logic [spsu_pkg::FILL_W-1:0]  fill_count
);

	import spsu_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = PRIORITY_BITS + TAG_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_INS  = 2'd3;

	logic [1:0]               state_q;
	logic [CW-1:0]            count_q;
	logic [AW-1:0]            ptr_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [TAG_BITS-1:0]      tag_q;
	logic                     valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic [PRIORITY_BITS-1:0] out_prio_q;
	logic [TAG_BITS-1:0]      out_tag_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [EW-1:0]            ram_wdata;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [EW-1:0]            ram_rdata;
	logic [PRIORITY_BITS-1:0] rd_prio;
	logic [TAG_BITS-1:0]      rd_tag;
	logic [AW-1:0]            top_addr;
	logic                     is_empty;
	logic                     is_full;
	logic                     higher;

	assign rd_prio  = ram_rdata[EW-1 -: PRIORITY_BITS];
	assign rd_tag   = ram_rdata[TAG_BITS-1:0];
	assign top_addr = AW'(count_q - CW'(1));
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));
	assign higher   = (rd_prio > prio_q);

	spsu_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Memory port control. During the downward walk the read runs one place
	// below the entry being moved, so the two ports never meet on one address.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = {prio_q, tag_q};
		ram_re    = 1'b0;
		ram_raddr = top_addr;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (action == ACT_POP) begin
						ram_re = !is_empty;
					end else if (is_empty) begin
						ram_we    = 1'b1;
						ram_wdata = {priority_req, tag};
					end else begin
						ram_re = !is_full;
					end
				end
			end
			S_SCAN: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q + AW'(1);
				if (higher) begin
					ram_wdata = ram_rdata;
					if (ptr_q != '0) begin
						ram_re    = 1'b1;
						ram_raddr = ptr_q - AW'(1);
					end
				end
			end
			S_INS: begin
				ram_we = 1'b1;
			end
			S_POP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (action == ACT_POP) begin
							if (is_empty) begin
								valid_q <= 1'b1;
							end else begin
								state_q <= S_POP;
							end
						end else if (is_full) begin
							valid_q <= 1'b1;
						end else if (is_empty) begin
							count_q <= CW'(1);
							valid_q <= 1'b1;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_POP: begin
					count_q <= count_q - CW'(1);
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (!higher) begin
						count_q <= count_q + CW'(1);
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (ptr_q == '0) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					count_q <= count_q + CW'(1);
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload and result payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					prio_q     <= priority_req;
					tag_q      <= tag;
					ptr_q      <= top_addr;
					out_prio_q <= '0;
					out_tag_q  <= '0;
					if (action == ACT_POP) begin
						status_q <= is_empty ? ST_EMPTY : ST_OK;
					end else begin
						status_q <= is_full ? ST_FULL : ST_OK;
					end
				end
			end
			S_POP: begin
				out_prio_q <= rd_prio;
				out_tag_q  <= rd_tag;
			end
			S_SCAN: begin
				if (higher && ptr_q != '0) begin
					ptr_q <= ptr_q - AW'(1);
				end
			end
			S_INS: begin
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = valid_q;
	assign status       = status_q;
	assign out_priority = out_prio_q;
	assign out_tag      = out_tag_q;
	assign fill_count   = FILL_W'(count_q);

	`SPSU_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count beyond depth")
	`SPSU_IMPLY(a_result_idle, valid_q, state_q == S_IDLE, "result shown while busy")
	`SPSU_IMPLY(a_empty_count, valid_q && status_q == ST_EMPTY, count_q == '0, "empty with entries")
	`SPSU_IMPLY(a_port_clash, ram_we && ram_re, ram_waddr != ram_raddr, "read and write on one entry")
	`SPSU_NEXT(a_pop_dec, state_q == S_POP, count_q == $past(count_q) - CW'(1), "pop did not remove one")

endmodule

>>> rtl/core/spsu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module spsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
